FILE: sv/cbm_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and constants for the cartridge bank mapper
// no dependencies; used by every module of the block

package cbm_pkg;

	// fixed geometry
	localparam int BANK_COUNT_DEF = 64;
	localparam int BANK_BYTES     = 8192;
	localparam int WIN_W          = $clog2(BANK_BYTES);
	localparam int RAM_BYTES      = 256;
	localparam int RAM_AW         = $clog2(RAM_BYTES);
	localparam int OFFSET_W       = 19;
	localparam int BANK_REG_W     = 6;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 6;
	localparam int TYPE_W         = 6;

	// bus commands
	typedef enum logic [3:0] {
		CMD_IO1_WR     = 4'd0,
		CMD_IO1_RD     = 4'd1,
		CMD_IO2_WR     = 4'd2,
		CMD_IO2_RD     = 4'd3,
		CMD_ROM_RD_LO  = 4'd4,
		CMD_ROM_RD_MID = 4'd5,
		CMD_ROM_RD_HI  = 4'd6,
		CMD_ROM_WR_LO  = 4'd7,
		CMD_ROM_WR_MID = 4'd8,
		CMD_ROM_WR_HI  = 4'd9,
		CMD_FREEZE     = 4'd10
	} cmd_t;

	// cartridge hardware types
	localparam logic [TYPE_W-1:0] CART_ACTION_REPLAY = 6'd1;
	localparam logic [TYPE_W-1:0] CART_FINAL_III     = 6'd3;
	localparam logic [TYPE_W-1:0] CART_SIMONS_BASIC  = 6'd4;
	localparam logic [TYPE_W-1:0] CART_OCEAN         = 6'd5;
	localparam logic [TYPE_W-1:0] CART_FUN_PLAY      = 6'd7;
	localparam logic [TYPE_W-1:0] CART_SUPER_GAMES   = 6'd8;
	localparam logic [TYPE_W-1:0] CART_ATOMIC_POWER  = 6'd9;
	localparam logic [TYPE_W-1:0] CART_GAME_SYSTEM   = 6'd15;
	localparam logic [TYPE_W-1:0] CART_DINAMIC       = 6'd17;
	localparam logic [TYPE_W-1:0] CART_EASYFLASH     = 6'd32;

	// result targets
	localparam logic [2:0] TGT_NONE    = 3'd0;
	localparam logic [2:0] TGT_LO_RD   = 3'd1;
	localparam logic [2:0] TGT_HI_RD   = 3'd2;
	localparam logic [2:0] TGT_RAM_WR  = 3'd3;
	localparam logic [2:0] TGT_LO_PROG = 3'd4;
	localparam logic [2:0] TGT_HI_PROG = 3'd5;

	// nmi actions (bit 0 assert, bit 1 release)
	localparam logic [1:0] NMI_NONE    = 2'd0;
	localparam int         NMI_ASSERT  = 0;
	localparam int         NMI_RELEASE = 1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CART_TYPE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INSERTED     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BOOT_JUMPER  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_HEADER_GAME  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_HEADER_EXROM = 3'd4;

	// bus addresses and data constants
	localparam logic [15:0]      ADDR_CTRL     = 16'hDE00;
	localparam logic [15:0]      ADDR_MODE     = 16'hDE02;
	localparam logic [7:0]       FC3_CTRL_LOW  = 8'hFF;
	localparam logic [WIN_W-1:0] FC3_IO1_BASE  = 13'h1E00;
	localparam logic [7:0]       FUN_PLAY_BITS = 8'h39;
	localparam logic [7:0]       SG_KILL       = 8'h0C;
	localparam logic [7:0]       FC3_FREEZE_V  = 8'h10;
	localparam logic [7:0]       NO_CART_ROM   = 8'h55;
	localparam logic [7:0]       OPEN_IO_DATA  = 8'hAA;

	typedef struct packed {
		logic [TYPE_W-1:0] cart_type;
		logic              inserted;
		logic              boot_jumper;
		logic              header_game;
		logic              header_exrom;
	} cfg_t;

	typedef struct packed {
		logic [BANK_REG_W-1:0] low_bank;
		logic [BANK_REG_W-1:0] high_bank;
		logic [1:0]            sub_bank;
		logic                  freezer_active;
		logic [BANK_REG_W-1:0] flash_bank;
		logic                  exrom_level;
		logic                  game_level;
		logic [1:0]            led_levels;
	} state_t;

	typedef struct packed {
		logic [3:0]  cmd;
		logic [15:0] address;
		logic [7:0]  data;
		logic        do_reset;
	} item_t;

	typedef struct packed {
		logic [7:0]          read_data;
		logic [2:0]          target;
		logic [OFFSET_W-1:0] rom_offset;
		logic                exrom_line;
		logic                game_line;
		logic [1:0]          nmi_action;
		logic                led_freeze;
		logic                led_status;
		logic                map_changed;
	} result_t;

	typedef struct packed {
		logic              we;
		logic [RAM_AW-1:0] addr;
		logic [7:0]        data;
	} ram_wr_t;

endpackage

FILE: sv/cbm_ram.sv
`timescale 1ns / 1ps
// 256-byte cartridge ram, one write port and one registered read port
// depends on cbm_pkg for the write bundle and the address width

module cbm_ram (
	input  logic                       clk,
	input  cbm_pkg::ram_wr_t           wr,
	input  logic                       rd_en,
	input  logic [cbm_pkg::RAM_AW-1:0] rd_addr,
	output logic [7:0]                 rd_data
);

	logic [7:0] mem_q [cbm_pkg::RAM_BYTES];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem_q[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: sv/cbm_decode.sv
`timescale 1ns / 1ps
// per-transaction decode: next bank and line state, result fields, ram write
// depends on cbm_pkg for types, commands and cartridge type codes

module cbm_decode #(
	parameter int BANK_COUNT = cbm_pkg::BANK_COUNT_DEF
) (
	input  cbm_pkg::state_t  st,
	input  cbm_pkg::cfg_t    cfg,
	input  cbm_pkg::item_t   item,
	input  logic [7:0]       ram_rdata,
	output cbm_pkg::state_t  st_next,
	output cbm_pkg::result_t res,
	output cbm_pkg::ram_wr_t ram_wr
);

	localparam int BANK_W = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;
	localparam int OW     = cbm_pkg::OFFSET_W;
	localparam int WW     = cbm_pkg::WIN_W;
	localparam int BW     = cbm_pkg::BANK_REG_W;
	localparam int NBANK  = 2 ** cbm_pkg::BANK_REG_W;

	// bank number folded into the image, worked out at elaboration
	logic [BANK_W-1:0] mod_tab [NBANK];

	for (genvar i = 0; i < NBANK; i++) begin : g_mod
		assign mod_tab[i] = BANK_W'(i % BANK_COUNT);
	end

	cbm_pkg::state_t   s;
	logic [2:0]        tgt;
	logic [7:0]        rdata;
	logic [1:0]        nmi;
	logic              map;
	logic [BW-1:0]     sel_bank;
	logic [WW-1:0]     win_addr;
	logic              fc3_en;
	logic [7:0]        fc3_v;
	logic              addr_ctrl;
	logic              addr_mode;
	logic [7:0]        v;
	logic [BANK_W-1:0] bank_m;

	assign addr_ctrl = item.address == cbm_pkg::ADDR_CTRL;
	assign addr_mode = item.address == cbm_pkg::ADDR_MODE;
	assign v         = item.data;

	always_comb begin
		s        = st;
		tgt      = cbm_pkg::TGT_NONE;
		rdata    = '0;
		nmi      = cbm_pkg::NMI_NONE;
		map      = 1'b0;
		sel_bank = st.low_bank;
		win_addr = item.address[WW-1:0];
		fc3_en   = 1'b0;
		fc3_v    = '0;
		ram_wr   = '0;

		if (item.do_reset) begin
			s.low_bank  = '0;
			s.high_bank = '0;
			if (!cfg.inserted) begin
				s.game_level  = 1'b1;
				s.exrom_level = 1'b1;
			end else begin
				unique case (cfg.cart_type)
					cbm_pkg::CART_ACTION_REPLAY: s.freezer_active = 1'b1;
					cbm_pkg::CART_FINAL_III: fc3_en = 1'b1;
					cbm_pkg::CART_ATOMIC_POWER: begin
					end
					cbm_pkg::CART_EASYFLASH: begin
						// control write of zero, then mode write of zero
						s.flash_bank    = '0;
						s.led_levels[1] = 1'b0;
						s.exrom_level   = 1'b1;
						s.game_level    = cfg.boot_jumper;
						map             = 1'b1;
					end
					default: begin
						s.game_level  = cfg.header_game;
						s.exrom_level = cfg.header_exrom;
					end
				endcase
			end
		end else begin
			unique case (cbm_pkg::cmd_t'(item.cmd))
				cbm_pkg::CMD_IO1_WR: begin
					if (cfg.inserted) begin
						unique case (cfg.cart_type)
							cbm_pkg::CART_ACTION_REPLAY: begin
								if (addr_ctrl) begin
									s.sub_bank    = {v[4], v[0]};
									s.exrom_level = v[3];
									s.game_level  = v[1];
									if (st.freezer_active) begin
										map = 1'b1;
										if (v[2]) begin
											s.freezer_active = 1'b0;
										end
									end
								end
							end
							cbm_pkg::CART_SIMONS_BASIC: begin
								if (addr_ctrl) begin
									s.game_level = 1'b0;
									map          = 1'b1;
								end
							end
							cbm_pkg::CART_OCEAN, cbm_pkg::CART_GAME_SYSTEM: begin
								s.low_bank = v[BW-1:0];
							end
							cbm_pkg::CART_FUN_PLAY: begin
								if (addr_ctrl && (v & ~cbm_pkg::FUN_PLAY_BITS) == 8'h00) begin
									s.low_bank = {2'b00, v[0], v[5:3]};
								end
							end
							cbm_pkg::CART_EASYFLASH: begin
								if (addr_ctrl) begin
									s.flash_bank = v[BW-1:0];
									s.low_bank   = v[BW-1:0];
									s.high_bank  = v[BW-1:0];
								end
								if (addr_mode) begin
									s.led_levels[1] = v[7];
									s.exrom_level   = ~v[1];
									s.game_level    = v[2] ? ~v[0] : cfg.boot_jumper;
									map             = 1'b1;
								end
							end
							default: begin
							end
						endcase
					end
				end
				cbm_pkg::CMD_IO1_RD: begin
					if (cfg.inserted) begin
						unique case (cfg.cart_type)
							cbm_pkg::CART_FINAL_III: begin
								tgt      = cbm_pkg::TGT_LO_RD;
								sel_bank = {{(BW - 2){1'b0}}, st.sub_bank};
								win_addr = cbm_pkg::FC3_IO1_BASE
									| {{(WW - 8){1'b0}}, item.address[7:0]};
							end
							cbm_pkg::CART_SIMONS_BASIC: begin
								if (addr_ctrl) begin
									s.game_level = 1'b1;
									map          = 1'b1;
								end
								rdata = cbm_pkg::OPEN_IO_DATA;
							end
							cbm_pkg::CART_DINAMIC: begin
								s.low_bank = item.address[BW-1:0];
								rdata      = cbm_pkg::OPEN_IO_DATA;
							end
							default: begin
							end
						endcase
					end
				end
				cbm_pkg::CMD_IO2_WR: begin
					if (cfg.inserted) begin
						unique case (cfg.cart_type)
							cbm_pkg::CART_FINAL_III: begin
								if (item.address[7:0] == cbm_pkg::FC3_CTRL_LOW) begin
									fc3_en = 1'b1;
									fc3_v  = v;
								end
							end
							cbm_pkg::CART_SUPER_GAMES: begin
								s.low_bank  = {{(BW - 2){1'b0}}, v[1:0]};
								s.high_bank = {{(BW - 2){1'b0}}, v[1:0]};
								if (v == cbm_pkg::SG_KILL) begin
									s.exrom_level = 1'b1;
									s.game_level  = 1'b1;
								end else begin
									s.exrom_level = 1'b0;
									s.game_level  = v[2];
								end
								map = 1'b1;
							end
							cbm_pkg::CART_EASYFLASH: begin
								ram_wr.we   = 1'b1;
								ram_wr.addr = item.address[cbm_pkg::RAM_AW-1:0];
								ram_wr.data = v;
							end
							default: begin
							end
						endcase
					end
				end
				cbm_pkg::CMD_IO2_RD: begin
					if (cfg.inserted) begin
						unique case (cfg.cart_type)
							cbm_pkg::CART_ACTION_REPLAY, cbm_pkg::CART_FINAL_III: begin
								// action replay maps its low rom bank here only while frozen
								if (st.freezer_active
									|| cfg.cart_type == cbm_pkg::CART_FINAL_III) begin
									tgt      = cbm_pkg::TGT_LO_RD;
									sel_bank = {{(BW - 2){1'b0}}, st.sub_bank};
								end
							end
							cbm_pkg::CART_EASYFLASH: rdata = ram_rdata;
							default: begin
							end
						endcase
					end
				end
				cbm_pkg::CMD_ROM_RD_LO, cbm_pkg::CMD_ROM_RD_MID, cbm_pkg::CMD_ROM_RD_HI: begin
					if (!cfg.inserted) begin
						rdata = cbm_pkg::NO_CART_ROM;
					end else begin
						if (cbm_pkg::cmd_t'(item.cmd) == cbm_pkg::CMD_ROM_RD_LO) begin
							tgt = cbm_pkg::TGT_LO_RD;
						end else begin
							tgt = cbm_pkg::TGT_HI_RD;
						end
						priority if (cfg.cart_type == cbm_pkg::CART_EASYFLASH) begin
							sel_bank = st.flash_bank;
						end else if (cbm_pkg::cmd_t'(item.cmd) == cbm_pkg::CMD_ROM_RD_LO
							&& cfg.cart_type == cbm_pkg::CART_ACTION_REPLAY) begin
							sel_bank = {{(BW - 2){1'b0}}, st.sub_bank};
						end else if (cbm_pkg::cmd_t'(item.cmd) == cbm_pkg::CMD_ROM_RD_LO) begin
							sel_bank = st.low_bank;
						end else begin
							sel_bank = st.high_bank;
						end
					end
				end
				cbm_pkg::CMD_ROM_WR_LO, cbm_pkg::CMD_ROM_WR_MID, cbm_pkg::CMD_ROM_WR_HI: begin
					if (cfg.inserted && cfg.cart_type == cbm_pkg::CART_EASYFLASH) begin
						if (cbm_pkg::cmd_t'(item.cmd) == cbm_pkg::CMD_ROM_WR_LO) begin
							tgt = cbm_pkg::TGT_LO_PROG;
						end else begin
							tgt = cbm_pkg::TGT_HI_PROG;
						end
						sel_bank = st.flash_bank;
					end else begin
						tgt = cbm_pkg::TGT_RAM_WR;
					end
				end
				cbm_pkg::CMD_FREEZE: begin
					if (cfg.inserted && cfg.cart_type == cbm_pkg::CART_FINAL_III) begin
						fc3_en = 1'b1;
						fc3_v  = cbm_pkg::FC3_FREEZE_V;
					end
				end
				default: begin
				end
			endcase
		end

		// final cartridge iii control register write
		if (fc3_en) begin
			s.sub_bank                   = fc3_v[1:0];
			s.low_bank                   = {{(BW - 2){1'b0}}, fc3_v[1:0]};
			s.high_bank                  = {{(BW - 2){1'b0}}, fc3_v[1:0]};
			s.exrom_level                = fc3_v[4];
			s.game_level                 = fc3_v[5];
			map                          = 1'b1;
			nmi[cbm_pkg::NMI_ASSERT]     = fc3_v[5:4] == 2'b01;
			nmi[cbm_pkg::NMI_RELEASE]    = fc3_v[6];
			s.led_levels[0]              = ~fc3_v[7];
		end
	end

	assign bank_m = mod_tab[sel_bank];

	always_comb begin
		res            = '0;
		res.read_data  = rdata;
		res.target     = tgt;
		// only rom and flash targets carry an image offset
		if (tgt == cbm_pkg::TGT_LO_RD || tgt == cbm_pkg::TGT_HI_RD
			|| tgt == cbm_pkg::TGT_LO_PROG || tgt == cbm_pkg::TGT_HI_PROG) begin
			res.rom_offset = OW'({bank_m, win_addr});
		end
		res.exrom_line  = s.exrom_level;
		res.game_line   = s.game_level;
		res.nmi_action  = nmi;
		res.led_freeze  = s.led_levels[0];
		res.led_status  = s.led_levels[1];
		res.map_changed = map;
	end

	assign st_next = s;

endmodule

FILE: sv/cartridge_bank_mapper.sv
`timescale 1ns / 1ps
// cartridge bank mapper top level: config registers, input and result stages, state
// depends on cbm_pkg, cbm_ram and cbm_decode
//
// channel   direction  handshake            payload
// cfg       in         cfg_we               cfg_index, cfg_data
// in        in         in_valid / in_stall  cmd, address, data, do_reset
// out       out        out_valid / out_stall read_data .. map_changed
//
// one transaction per cycle while out_stall is low; each passes the input stage, then the result register
// the decode between the input stage and the result register sets the cycle budget
// bank state and the ram write commit when a transaction moves into the result register
// a held result stalls the input stage; the input is stalled only when both stages are full
// reset clears the bank state, leds and config but sets the lines and header bits high; the ram holds no reset value

module cartridge_bank_mapper #(
	parameter int BANK_COUNT = cbm_pkg::BANK_COUNT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [cbm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cbm_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [3:0]                     cmd,
	input  logic [15:0]                    address,
	input  logic [7:0]                     data,
	input  logic                           do_reset,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [7:0]                     read_data,
	output logic [2:0]                     target,
	output logic [cbm_pkg::OFFSET_W-1:0]   rom_offset,
	output logic                           exrom_line,
	output logic                           game_line,
	output logic [1:0]                     nmi_action,
	output logic                           led_freeze,
	output logic                           led_status,
	output logic                           map_changed
);

	localparam int AW = cbm_pkg::RAM_AW;

	cbm_pkg::cfg_t    cfg_q;
	cbm_pkg::state_t  st_q;
	cbm_pkg::state_t  st_next;
	cbm_pkg::item_t   item_s1;
	cbm_pkg::result_t res;
	cbm_pkg::result_t res_s2;
	cbm_pkg::ram_wr_t dec_wr;
	cbm_pkg::ram_wr_t ram_wr;
	logic             valid_s1;
	logic             valid_s2;
	logic             fwd_s1;
	logic [7:0]       fwd_data_s1;
	logic             in_accept;
	logic             adv;
	logic             fwd_hit;
	logic [7:0]       ram_rd_data;
	logic [7:0]       ram_rdata;

	assign adv       = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall  = valid_s1 && !adv;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{cart_type: '0, inserted: 1'b0, boot_jumper: 1'b0,
				header_game: 1'b1, header_exrom: 1'b1};
		end else if (cfg_we) begin
			unique case (cfg_index)
				cbm_pkg::CFG_CART_TYPE:    cfg_q.cart_type    <= cfg_data[cbm_pkg::TYPE_W-1:0];
				cbm_pkg::CFG_INSERTED:     cfg_q.inserted     <= cfg_data[0];
				cbm_pkg::CFG_BOOT_JUMPER:  cfg_q.boot_jumper  <= cfg_data[0];
				cbm_pkg::CFG_HEADER_GAME:  cfg_q.header_game  <= cfg_data[0];
				cbm_pkg::CFG_HEADER_EXROM: cfg_q.header_exrom <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			st_q     <= '{low_bank: '0, high_bank: '0, sub_bank: '0, freezer_active: 1'b0,
				flash_bank: '0, exrom_level: 1'b1, game_level: 1'b1, led_levels: '0};
		end else begin
			if (in_accept) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
				st_q     <= st_next;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// a ram write committing in the same cycle as a read of that byte is forwarded
	assign fwd_hit = ram_wr.we && ram_wr.addr == address[AW-1:0];

	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_s1     <= '{cmd: cmd, address: address, data: data, do_reset: do_reset};
			fwd_s1      <= fwd_hit;
			fwd_data_s1 <= ram_wr.data;
		end
		if (adv) begin
			res_s2 <= res;
		end
	end

	always_comb begin
		ram_wr    = dec_wr;
		ram_wr.we = dec_wr.we && adv;
	end

	cbm_ram u_ram (
		.clk     (clk),
		.wr      (ram_wr),
		.rd_en   (in_accept),
		.rd_addr (address[AW-1:0]),
		.rd_data (ram_rd_data)
	);

	assign ram_rdata = fwd_s1 ? fwd_data_s1 : ram_rd_data;

	cbm_decode #(
		.BANK_COUNT (BANK_COUNT)
	) u_decode (
		.st        (st_q),
		.cfg       (cfg_q),
		.item      (item_s1),
		.ram_rdata (ram_rdata),
		.st_next   (st_next),
		.res       (res),
		.ram_wr    (dec_wr)
	);

	assign out_valid   = valid_s2;
	assign read_data   = res_s2.read_data;
	assign target      = res_s2.target;
	assign rom_offset  = res_s2.rom_offset;
	assign exrom_line  = res_s2.exrom_line;
	assign game_line   = res_s2.game_line;
	assign nmi_action  = res_s2.nmi_action;
	assign led_freeze  = res_s2.led_freeze;
	assign led_status  = res_s2.led_status;
	assign map_changed = res_s2.map_changed;

endmodule

FILE: sv/cbm_checker.sv
`timescale 1ns / 1ps
// port-level checks for the cartridge bank mapper, bound to the top level
// depends on cbm_pkg for target and nmi codes

module cbm_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_stall,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [7:0]                     read_data,
	input logic [2:0]                     target,
	input logic [cbm_pkg::OFFSET_W-1:0]   rom_offset,
	input logic [1:0]                     nmi_action,
	input logic                           map_changed
);

	// a free result side never holds up the input
	a_no_stall_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled while result side is free");

	// memory targets carry no read byte
	a_data_only_without_target: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && target != cbm_pkg::TGT_NONE |-> read_data == 8'h00)
		else $error("read byte given alongside a memory target");

	// plain data and ram writes carry no image offset
	a_offset_only_for_image: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (target == cbm_pkg::TGT_NONE || target == cbm_pkg::TGT_RAM_WR)
		|-> rom_offset == '0)
		else $error("image offset given without an image target");

	// nmi changes only come with a control register update that also remaps
	a_nmi_implies_remap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && nmi_action != cbm_pkg::NMI_NONE |-> map_changed)
		else $error("nmi action without memory map change");

	a_held_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(target) && $stable(rom_offset)
		&& $stable(read_data))
		else $error("stalled result changed");

endmodule

bind cartridge_bank_mapper cbm_checker u_cbm_checker (.*);
